/* hw/rtl/bsa_pkg.sv */
// Shared types, constants and status codes of the bitmap slot allocator.
`timescale 1ns / 1ps

package bsa_pkg;

   // Pool geometry defaults
   localparam int SLOTS_DEFAULT       = 16384;
   localparam int BLOCK_BYTES_DEFAULT = 64;

   // Bitmap organization: one 64-bit word per memory entry
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = 6;
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_IDX_W = 4;

   // Depth of the command queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Field widths
   localparam int SLOT_FIELD_W   = 14;
   localparam int OFFSET_FIELD_W = 20;
   localparam int COUNT_FIELD_W  = 15;
   localparam int STATUS_W       = 2;

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd2;

   // Command classes decided by the front
   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      logic                    operation;
      logic [SLOT_FIELD_W-1:0] slot_to_free;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0]   slot;
      logic [OFFSET_FIELD_W-1:0] byte_offset;
      logic [COUNT_FIELD_W-1:0]  in_use_count;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [SLOT_FIELD_W-1:0] target;
   } cmd_type;

endpackage

/* hw/rtl/bitmap_slot_allocator.sv */
// Top level of the bitmap slot allocator: front, command queue and back.
`timescale 1ns / 1ps

// Fixed-size slot allocator over a free bitmap held in a 64-bit-wide RAM.
// Request channel: a word on req_data is taken at a rising edge with start
// high and busy low. operation 0 allocates the lowest free slot, 1 frees
// slot_to_free. busy rises only when the command queue is full and the
// front still holds a command.
// Result channel: rsp_valid is high for one cycle with rsp_data; the
// receiver cannot stall, so every result must be taken in that cycle.
// The back-end sequencer and its single map RAM port work on one command at
// a time; the front and queue take new requests while it works until the
// queue fills. Allocate steps through group search, word search,
// read-modify-write and result; free through read, read-modify-write and
// result; allocate into a full pool and rejected free go to the result.
// Results leave in request order.
// Reset: every slot free, count zero. Per-word valid bits stand in for the
// RAM contents until a word is first written, so no clearing pass is run.
module bitmap_slot_allocator #(
   parameter int SLOTS       = bsa_pkg::SLOTS_DEFAULT,
   parameter int BLOCK_BYTES = bsa_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bsa_pkg::req_type req_data,
   output logic             rsp_valid,
   output bsa_pkg::rsp_type rsp_data
);
   import bsa_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head;

   bsa_front #(
      .SLOTS(SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .queue_full(queue_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   bsa_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head      (head)
   );

   bsa_back #(
      .SLOTS      (SLOTS),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/bsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bsa_front.sv */
// Front end: takes request words and classifies them into commands.
`timescale 1ns / 1ps

module bsa_front #(
   parameter int SLOTS = bsa_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bsa_pkg::req_type req_data,
   input  logic             queue_full,
   output logic             push,
   output bsa_pkg::cmd_type push_cmd
);
   import bsa_pkg::*;

   logic    cmd_valid_ff, cmd_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   // Stall the requester only while a command waits on a full queue
   assign busy   = cmd_valid_ff && queue_full;
   assign accept = start && !busy;
   assign push   = cmd_valid_ff && !queue_full;

   // Classify the incoming word
   always_comb begin
      cmd_in        = cmd_ff;
      cmd_valid_in  = cmd_valid_ff && !push;
      if (accept) begin
         cmd_valid_in  = 1'b1;
         cmd_in.target = req_data.slot_to_free;
         if (req_data.operation == OP_ALLOC) begin
            cmd_in.kind = CMD_ALLOC;
         end else if (32'(req_data.slot_to_free) >= SLOTS) begin
            cmd_in.kind = CMD_REJECT;
         end else begin
            cmd_in.kind = CMD_FREE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         cmd_ff       <= cmd_in;
      end
   end

   assign push_cmd = cmd_ff;

endmodule

/* hw/rtl/bsa_queue.sv */
// Short command queue that decouples the front from the back.
`timescale 1ns / 1ps

module bsa_queue #(
   parameter int DEPTH = bsa_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bsa_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output bsa_pkg::cmd_type head
);
   import bsa_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/bsa_back.sv */
// Back end: executes commands against the free bitmap and forms result words.
`timescale 1ns / 1ps

module bsa_back #(
   parameter int SLOTS       = bsa_pkg::SLOTS_DEFAULT,
   parameter int BLOCK_BYTES = bsa_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  bsa_pkg::cmd_type head,
   output logic             pop,
   output logic             rsp_valid,
   output bsa_pkg::rsp_type rsp_data
);
   import bsa_pkg::*;

   localparam int MAP_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int GROUPS    = (MAP_WORDS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAD_W     = GROUPS * GROUP_SIZE;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int BB_W      = $clog2(BLOCK_BYTES + 1);
   localparam int PROD_W    = SLOT_W + BB_W;
   localparam int LAST_BITS = SLOTS - (MAP_WORDS - 1) * WORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WORD,
      ST_ALLOC,
      ST_FREE,
      ST_RESP
   } state_type;

   // Contents of a word never written: free bits for slots inside the pool
   function automatic logic [WORD_BITS-1:0] reset_word(input logic [WORD_W-1:0] w);
      logic [WORD_BITS-1:0] m;
      m = {WORD_BITS{1'b1}};
      if (int'(w) == MAP_WORDS - 1) begin
         m = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
      end
      return m;
   endfunction

   function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) idx = BIT_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [GROUP_IDX_W-1:0] first_in_group(
      input logic [GROUP_SIZE-1:0] v);
      logic [GROUP_IDX_W-1:0] idx;
      idx = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (v[i]) idx = GROUP_IDX_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [GRP_W-1:0] first_group(input logic [GROUPS-1:0] v);
      logic [GRP_W-1:0] idx;
      idx = '0;
      for (int i = GROUPS - 1; i >= 0; i--) begin
         if (v[i]) idx = GRP_W'(i);
      end
      return idx;
   endfunction

   state_type                state_ff, state_in;
   logic [GRP_W-1:0]         grp_ff, grp_in;
   logic [WORD_W-1:0]        word_ff, word_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic [SLOT_FIELD_W-1:0]  target_ff, target_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [MAP_WORDS-1:0]     valid_ff, valid_in;
   logic [MAP_WORDS-1:0]     summary_ff, summary_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [PAD_W-1:0]         summary_pad;
   logic [GROUPS-1:0]        group_any;
   logic [GROUP_SIZE-1:0]    group_bits;
   logic [WORD_W-1:0]        found_word;
   logic [WORD_BITS-1:0]     ram_q;
   logic [WORD_BITS-1:0]     word_data;
   logic [BIT_W-1:0]         alloc_bit;
   logic [PROD_W-1:0]        product;
   logic                     rd_en;
   logic [WORD_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [WORD_W-1:0]        wr_addr;
   logic [WORD_BITS-1:0]     wr_data;

   // Summarize non-empty words per group of sixteen
   assign summary_pad = PAD_W'(summary_ff);
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_any[g] = |summary_pad[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   assign group_bits = summary_pad[grp_ff*GROUP_SIZE +: GROUP_SIZE];
   assign found_word = WORD_W'({grp_ff, first_in_group(group_bits)});

   // Word read back from the map; unwritten words take their reset value
   assign word_data = valid_ff[word_ff] ? ram_q : reset_word(word_ff);
   assign alloc_bit = first_bit(word_data);
   assign product   = PROD_W'(slot_ff) * PROD_W'(BLOCK_BYTES);

   bsa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAP_WORDS),
      .ADDR_W(WORD_W)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   // Sequence one command at a time
   always_comb begin
      state_in     = state_ff;
      grp_in       = grp_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      target_in    = target_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      summary_in   = summary_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = word_ff;
      wr_en        = 1'b0;
      wr_addr      = word_ff;
      wr_data      = word_data;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop       = 1'b1;
               target_in = head.target;
               case (head.kind)
                  CMD_ALLOC: begin
                     if (summary_ff == '0) begin
                        slot_in   = '0;
                        status_in = STATUS_FULL;
                        state_in  = ST_RESP;
                     end else begin
                        grp_in   = first_group(group_any);
                        state_in = ST_WORD;
                     end
                  end
                  CMD_FREE: begin
                     word_in  = WORD_W'(head.target >> BIT_W);
                     bit_in   = head.target[BIT_W-1:0];
                     rd_en    = 1'b1;
                     rd_addr  = WORD_W'(head.target >> BIT_W);
                     state_in = ST_FREE;
                  end
                  default: begin
                     slot_in   = '0;
                     status_in = STATUS_ALREADY_FREE;
                     state_in  = ST_RESP;
                  end
               endcase
            end
         end
         ST_WORD: begin
            word_in  = found_word;
            rd_en    = 1'b1;
            rd_addr  = found_word;
            state_in = ST_ALLOC;
         end
         ST_ALLOC: begin
            // Take the lowest free bit of the word
            wr_en                = 1'b1;
            wr_data              = word_data & ~(WORD_BITS'(1) << alloc_bit);
            valid_in[word_ff]    = 1'b1;
            summary_in[word_ff]  = |wr_data;
            count_in             = count_ff + 1'b1;
            slot_in              = SLOT_W'({word_ff, alloc_bit});
            status_in            = STATUS_DONE;
            state_in             = ST_RESP;
         end
         ST_FREE: begin
            if (word_data[bit_ff]) begin
               slot_in   = '0;
               status_in = STATUS_ALREADY_FREE;
            end else begin
               wr_en               = 1'b1;
               wr_data             = word_data | (WORD_BITS'(1) << bit_ff);
               valid_in[word_ff]   = 1'b1;
               summary_in[word_ff] = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               slot_in   = SLOT_W'(target_ff);
               status_in = STATUS_DONE;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in        = 1'b1;
            rsp_in.slot         = SLOT_FIELD_W'(slot_ff);
            rsp_in.byte_offset  = OFFSET_FIELD_W'(product);
            rsp_in.in_use_count = COUNT_FIELD_W'(count_ff);
            rsp_in.status       = status_ff;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         valid_ff     <= '0;
         for (int w = 0; w < MAP_WORDS; w++) begin
            summary_ff[w] <= 1'b1;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grp_ff       <= grp_in;
         word_ff      <= word_in;
         bit_ff       <= bit_in;
         target_ff    <= target_in;
         slot_ff      <= slot_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         summary_ff   <= summary_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // The summary only points at words that still hold a free bit
   a_alloc_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |-> (word_data != '0))
      else $error("allocation from a word with no free slot");

   // The in-use count stays within the pool
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("in-use count exceeds pool size");

   // Full is reported only when every slot is in use
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && status_ff == STATUS_FULL) |-> (count_ff == CNT_W'(SLOTS)))
      else $error("pool full reported with free slots left");

endmodule

/* dv/bitmap_slot_allocator_tb.sv */
// Self-checking testbench for the bitmap slot allocator: directed table and random churn.
`timescale 1ns / 1ps

module bitmap_slot_allocator_tb;
   import bsa_pkg::*;

   localparam int POOL_SLOTS  = 16384;
   localparam int BLOCK       = 64;
   localparam int MAP_WORDS   = POOL_SLOTS / WORD_BITS;
   localparam int RANDOM_WORDS = 320;
   localparam int CHURN_WORDS  = 60;
   localparam int MAX_REPORTS  = 10;

   // One line of the directed table: the request word, and the reply where it is known
   typedef struct packed {
      req_type cmd;
      logic    typed;
      rsp_type reply;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow allocator state
   logic [WORD_BITS-1:0] shadow_free_words [MAP_WORDS];
   int unsigned          shadow_taken;
   int                   taken_slots [$];

   rsp_type     awaited_rsps [$];
   rsp_type     head_rsp;
   int          mismatches;
   dir_row_type dir_rows [$];
   req_type     next_cmd;
   int          i;
   int          pick;

   bitmap_slot_allocator #(
      .SLOTS       (POOL_SLOTS),
      .BLOCK_BYTES (BLOCK)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Give up long after the slowest correct run would have ended
   initial begin
      #10_000_000;
      $display("bitmap_slot_allocator_tb: FAIL");
      $finish;
   end

   // Put the shadow map back to all slots free
   task automatic clear_shadow();
      int w;
      for (w = 0; w < MAP_WORDS; w++) begin
         shadow_free_words[w] = '1;
      end
      shadow_taken = 0;
      taken_slots.delete();
   endtask

   function automatic rsp_type grant_reply(input int unsigned slot_num, input logic [1:0] code);
      rsp_type     o;
      logic [31:0] offs;
      offs = slot_num * BLOCK;
      o.slot         = slot_num[SLOT_FIELD_W-1:0];
      o.byte_offset  = offs[OFFSET_FIELD_W-1:0];
      o.in_use_count = shadow_taken[COUNT_FIELD_W-1:0];
      o.status       = code;
      return o;
   endfunction

   // Apply one request to the shadow map and return the reply it must produce
   function automatic rsp_type apply_request(input req_type r);
      int          w;
      int          b;
      int          k;
      int unsigned tgt;
      logic        found;
      rsp_type     o;
      o     = grant_reply(0, STATUS_FULL);
      found = 1'b0;
      tgt   = 32'(r.slot_to_free);
      if (r.operation == OP_ALLOC) begin
         // Take the lowest set bit, skipping empty words
         for (w = 0; w < MAP_WORDS && !found; w++) begin
            if (shadow_free_words[w] != '0) begin
               for (b = 0; b < WORD_BITS && !found; b++) begin
                  if (shadow_free_words[w][b]) begin
                     found = 1'b1;
                     shadow_free_words[w][b] = 1'b0;
                     shadow_taken++;
                     taken_slots.insert(taken_slots.size(), w * WORD_BITS + b);
                     o = grant_reply(w * WORD_BITS + b, STATUS_DONE);
                  end
               end
            end
         end
      end else if (tgt >= POOL_SLOTS || shadow_free_words[tgt / WORD_BITS][tgt % WORD_BITS]) begin
         o = grant_reply(0, STATUS_ALREADY_FREE);
      end else begin
         shadow_free_words[tgt / WORD_BITS][tgt % WORD_BITS] = 1'b1;
         if (shadow_taken > 0) shadow_taken--;
         for (k = 0; k < taken_slots.size(); k++) begin
            if (taken_slots[k] == tgt) begin
               taken_slots.delete(k);
               break;
            end
         end
         o = grant_reply(tgt, STATUS_DONE);
      end
      return o;
   endfunction

   function automatic int pick_gap(input logic no_gaps);
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic dir_row_type mk_row(input logic op, input int unsigned tgt,
                                          input logic typed,
                                          input int unsigned eslot, input int unsigned ecount,
                                          input logic [1:0] ecode);
      dir_row_type row;
      logic [31:0] offs;
      offs = eslot * BLOCK;
      row.cmd.operation       = op;
      row.cmd.slot_to_free    = tgt[SLOT_FIELD_W-1:0];
      row.typed               = typed;
      row.reply.slot          = eslot[SLOT_FIELD_W-1:0];
      row.reply.byte_offset   = offs[OFFSET_FIELD_W-1:0];
      row.reply.in_use_count  = ecount[COUNT_FIELD_W-1:0];
      row.reply.status        = ecode;
      return row;
   endfunction

   // Append one line to the directed table
   task automatic add_row(input dir_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // Called at a falling edge; hold start low for the gap, present the word, wait for the take
   task automatic send_word(input req_type w, input int gap, input logic typed,
                            input rsp_type typed_rsp);
      rsp_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_request(w);
      awaited_rsps.insert(awaited_rsps.size(), typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic send_cmd(input logic op, input int unsigned tgt, input logic no_gaps);
      req_type w;
      w.operation    = op;
      w.slot_to_free = tgt[SLOT_FIELD_W-1:0];
      send_word(w, pick_gap(no_gaps), 1'b0, '0);
   endtask

   // Hold the sender until every reply owed has come back
   task automatic drain_replies();
      start <= 1'b0;
      do @(negedge clock); while (awaited_rsps.size() != 0);
   endtask

   // Pick a free of a held slot, a free of any slot, or an allocate
   task automatic churn_word(input int alloc_pct, input int free_pct);
      int r;
      r = $urandom_range(0, 99);
      if (taken_slots.size() == 0 || r < alloc_pct) begin
         send_cmd(OP_ALLOC, $urandom_range(0, POOL_SLOTS - 1), 1'b0);
      end else if (r < alloc_pct + free_pct) begin
         pick = $urandom_range(0, taken_slots.size() - 1);
         send_cmd(OP_FREE, taken_slots[pick], 1'b0);
      end else begin
         send_cmd(OP_FREE, $urandom_range(0, POOL_SLOTS - 1), 1'b0);
      end
   endtask

   // Compare each reply word against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected reply: slot %0d offset %0d count %0d status %0d",
                        rsp_data.slot, rsp_data.byte_offset, rsp_data.in_use_count,
                        rsp_data.status);
         end else begin
            head_rsp = awaited_rsps.pop_front();
            if (head_rsp.slot !== rsp_data.slot ||
                head_rsp.byte_offset !== rsp_data.byte_offset ||
                head_rsp.in_use_count !== rsp_data.in_use_count ||
                head_rsp.status !== rsp_data.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("reply mismatch at %0t: exp slot %0d offset %0d count %0d status %0d,",
                           $realtime, head_rsp.slot, head_rsp.byte_offset,
                           head_rsp.in_use_count, head_rsp.status,
                           " got slot %0d offset %0d count %0d status %0d", rsp_data.slot,
                           rsp_data.byte_offset, rsp_data.in_use_count, rsp_data.status);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      clear_shadow();

      // Directed table: typed replies where they follow directly from reset
      add_row(mk_row(OP_ALLOC, 16383, 1'b1, 0, 1, STATUS_DONE));
      add_row(mk_row(OP_ALLOC, 0,     1'b1, 1, 2, STATUS_DONE));
      add_row(mk_row(OP_ALLOC, 5461,  1'b1, 2, 3, STATUS_DONE));
      add_row(mk_row(OP_FREE,  1,     1'b1, 1, 2, STATUS_DONE));
      add_row(mk_row(OP_FREE,  1,     1'b1, 0, 2, STATUS_ALREADY_FREE));
      add_row(mk_row(OP_ALLOC, 10922, 1'b1, 1, 3, STATUS_DONE));
      add_row(mk_row(OP_FREE,  16383, 1'b1, 0, 3, STATUS_ALREADY_FREE));
      add_row(mk_row(OP_FREE,  0,     1'b1, 0, 2, STATUS_DONE));
      add_row(mk_row(OP_FREE,  0,     1'b1, 0, 2, STATUS_ALREADY_FREE));
      add_row(mk_row(OP_ALLOC, 8191,  1'b1, 0, 3, STATUS_DONE));
      add_row(mk_row(OP_FREE,  8191,  1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_FREE,  10922, 1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_FREE,  5461,  1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_FREE,  64,    1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_ALLOC, 8192,  1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_FREE,  2,     1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_ALLOC, 0,     1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_FREE,  3,     1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_FREE,  3,     1'b0, 0, 0, STATUS_DONE));
      add_row(mk_row(OP_ALLOC, 0,     1'b0, 0, 0, STATUS_DONE));

      // Hold reset, then release at a falling edge
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table: the typed rows back to back, the rest with random gaps
      for (i = 0; i < dir_rows.size(); i++) begin
         send_word(dir_rows[i].cmd, (i < 10) ? 0 : pick_gap(1'b0), dir_rows[i].typed,
                   dir_rows[i].reply);
      end
      drain_replies();

      // Random churn, leaning toward allocation so the pool grows across several words
      for (i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 59) == 0) drain_replies();
         if ((i / 100) % 2 == 1 && (i % 100) < 30) begin
            next_cmd.operation    = OP_ALLOC;
            next_cmd.slot_to_free = SLOT_FIELD_W'($urandom_range(0, POOL_SLOTS - 1));
            send_word(next_cmd, 0, 1'b0, '0);
         end else begin
            churn_word(55, 35);
         end
      end
      drain_replies();

      // Balanced churn of frees and allocations
      for (i = 0; i < CHURN_WORDS; i++) begin
         churn_word(45, 45);
      end

      // Stop sending, wait out every owed reply and a few more cycles
      drain_replies();
      repeat (16) @(posedge clock);
      mismatches += awaited_rsps.size();
      if (mismatches == 0) begin
         $display("bitmap_slot_allocator_tb: PASS");
      end else begin
         $display("bitmap_slot_allocator_tb: FAIL");
      end
      $finish;
   end

endmodule
